/* rtl/cordic_sc_pkg.sv */
// shared types, constants and arctangent table for the cordic sine/cosine unit
`timescale 1ns / 1ps

package cordic_sc_pkg;

   // number of cordic rotation steps (8 to 18)
   localparam int ROTATION_STEPS = 12;
   // fraction bits of the residual angle (0 to 16)
   localparam int RESIDUAL_FRACTION_BITS = 8;

   // field widths
   localparam int ANGLE_W = 16;
   localparam int TRIG_W  = 16;
   localparam int FOLD_W  = 14;
   // residual holds a signed angle of up to about one full turn with its fraction bits
   localparam int RES_W   = RESIDUAL_FRACTION_BITS + 16;
   // rotating vector peaks near 2^26
   localparam int XY_W    = 29;
   localparam int SHIFT_W = 5;
   localparam int TABLE_LEN = 18;

   // angle landmarks in counts
   localparam logic [ANGLE_W-2:0] QUARTER       = 15'd8192;
   localparam logic [ANGLE_W-2:0] HALF          = 15'd16384;
   localparam logic [ANGLE_W-2:0] THREE_QUARTER = 15'd24576;
   localparam logic [ANGLE_W-1:0] FULL_TURN     = 16'd32768;

   // start vector, pre-divided by the cordic gain
   localparam logic signed [XY_W-1:0] START_X = 29'sd40752061;
   localparam int OUT_SHIFT = 11;

   // arctangent of 2^-i in counts, scaled by 2^16
   localparam longint ATAN_Q16 [TABLE_LEN] = '{
      268435456, 158466703, 83729449, 42502377, 21333665, 10677230,
      5339919, 2670123, 1335082, 667543, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608
   };

   // data carried between pipeline stages
   typedef struct packed {
      logic signed [XY_W-1:0]  x;
      logic signed [XY_W-1:0]  y;
      logic signed [RES_W-1:0] r;
      logic                    neg_x;
      logic                    neg_y;
   } vec_type;

   // arctangent constant at the residual fraction width, rounded half up
   function automatic logic signed [RES_W-1:0] atan_const(input int idx);
      longint c;
      c = ATAN_Q16[idx];
      if (RESIDUAL_FRACTION_BITS < 16) begin
         c = (c + (64'sd1 <<< (15 - RESIDUAL_FRACTION_BITS)))
             >>> (16 - RESIDUAL_FRACTION_BITS);
      end
      return c[RES_W-1:0];
   endfunction

endpackage

/* rtl/cordic_sin_cos_unit.sv */
// cordic sine and cosine unit, fully pipelined, top level
//
// channel  direction  payload
// req_     in         tdata[15:0] turn_angle
// rsp_     out        tdata[15:0] cosine, tdata[31:16] sine
//
// one angle accepted per cycle unless back-pressure on rsp_ stalls the pipeline; registers in
// order: fold register, one register per rotation step, output register
// reset clears all stage valid bits; payload registers are not reset
// each stage holds its item while the next one is full and stalled, so an
// empty stage still takes a new transaction while a result waits on rsp_
`timescale 1ns / 1ps

module cordic_sin_cos_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] turn_angle
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [15:0] cosine, [31:16] sine
);

   localparam int STEPS = cordic_sc_pkg::ROTATION_STEPS;
   localparam int XY_W  = cordic_sc_pkg::XY_W;
   localparam int SH_W  = XY_W - cordic_sc_pkg::OUT_SHIFT;

   // pipeline links: step_data[k] feeds step k, step_data[STEPS] feeds output
   cordic_sc_pkg::vec_type step_data  [STEPS+1];
   logic                   step_valid [STEPS+1];
   logic                   step_ready [STEPS+1];

   logic                   s0_vld_ff;
   cordic_sc_pkg::vec_type s0_data_ff;
   cordic_sc_pkg::vec_type s0_data_in;

   logic [cordic_sc_pkg::ANGLE_W-2:0] angle;
   logic [cordic_sc_pkg::FOLD_W-1:0]  fold;

   logic                               out_ready;
   logic                               rsp_tvalid_ff;
   logic [31:0]                        rsp_tdata_ff;
   logic [31:0]                        rsp_tdata_in;
   logic signed [XY_W-1:0]             x_sign;
   logic signed [XY_W-1:0]             y_sign;
   logic signed [XY_W-1:0]             x_shift;
   logic signed [XY_W-1:0]             y_shift;

   // clamp a shifted value to the 16-bit signed range
   function automatic logic [15:0] sat16(input logic signed [SH_W-1:0] v);
      logic [15:0] res;
      if (v > SH_W'(32767)) begin
         res = 16'h7fff;
      end else if (v < -SH_W'(32768)) begin
         res = 16'h8000;
      end else begin
         res = v[15:0];
      end
      return res;
   endfunction

   // wrap to one turn and fold into the first quadrant
   always_comb begin
      angle = req_tdata[cordic_sc_pkg::ANGLE_W-2:0];
      s0_data_in.x = cordic_sc_pkg::START_X;
      s0_data_in.y = '0;
      if (angle <= cordic_sc_pkg::QUARTER) begin
         fold = angle[cordic_sc_pkg::FOLD_W-1:0];
         s0_data_in.neg_x = 1'b0;
         s0_data_in.neg_y = 1'b0;
      end else if (angle <= cordic_sc_pkg::HALF) begin
         fold = cordic_sc_pkg::FOLD_W'(cordic_sc_pkg::HALF - angle);
         s0_data_in.neg_x = 1'b1;
         s0_data_in.neg_y = 1'b0;
      end else if (angle <= cordic_sc_pkg::THREE_QUARTER) begin
         fold = cordic_sc_pkg::FOLD_W'(angle - cordic_sc_pkg::HALF);
         s0_data_in.neg_x = 1'b1;
         s0_data_in.neg_y = 1'b1;
      end else begin
         fold = cordic_sc_pkg::FOLD_W'(cordic_sc_pkg::FULL_TURN - {1'b0, angle});
         s0_data_in.neg_x = 1'b0;
         s0_data_in.neg_y = 1'b1;
      end
      s0_data_in.r = cordic_sc_pkg::RES_W'(fold) <<< cordic_sc_pkg::RESIDUAL_FRACTION_BITS;
   end

   assign req_tready = !s0_vld_ff || step_ready[0];

   // fold stage valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (req_tready) begin
         s0_vld_ff <= req_tvalid;
      end
   end

   // fold stage payload
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s0_data_ff <= s0_data_in;
      end
   end

   assign step_data[0]  = s0_data_ff;
   assign step_valid[0] = s0_vld_ff;

   // rotation steps
   for (genvar k = 0; k < STEPS; k++) begin : g_step
      cordic_sc_step u_step (
         .clock      (clock),
         .reset      (reset),
         .step_shift (cordic_sc_pkg::SHIFT_W'(k)),
         .step_atan  (cordic_sc_pkg::atan_const(k)),
         .up_valid   (step_valid[k]),
         .up_ready   (step_ready[k]),
         .up_data    (step_data[k]),
         .down_valid (step_valid[k+1]),
         .down_ready (step_ready[k+1]),
         .down_data  (step_data[k+1])
      );
   end

   assign out_ready         = !rsp_tvalid_ff || rsp_tready;
   assign step_ready[STEPS] = out_ready;

   // restore signs per sector, scale down and saturate
   always_comb begin
      x_sign  = step_data[STEPS].neg_x ? -step_data[STEPS].x : step_data[STEPS].x;
      y_sign  = step_data[STEPS].neg_y ? -step_data[STEPS].y : step_data[STEPS].y;
      x_shift = x_sign >>> cordic_sc_pkg::OUT_SHIFT;
      y_shift = y_sign >>> cordic_sc_pkg::OUT_SHIFT;
      rsp_tdata_in = {sat16(y_shift[SH_W-1:0]), sat16(x_shift[SH_W-1:0])};
   end

   // output valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_tvalid_ff <= step_valid[STEPS];
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (out_ready && step_valid[STEPS]) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

`ifndef ASSERT_OFF
   // an accepted angle lands in the fold stage
   a_fold_load: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> s0_vld_ff)
      else $error("accepted transaction missing from fold stage");

   // a stalled fold stage keeps its item
   a_fold_hold: assert property (@(posedge clock) disable iff (reset)
      (s0_vld_ff && !step_ready[0]) |=> (s0_vld_ff && $stable(s0_data_ff)))
      else $error("fold stage lost or changed a stalled item");

   // a stalled last rotation step keeps its item
   a_last_hold: assert property (@(posedge clock) disable iff (reset)
      (step_valid[STEPS] && !out_ready) |=>
      (step_valid[STEPS] && $stable(step_data[STEPS])))
      else $error("last rotation step lost or changed a stalled item");
`endif

endmodule

/* rtl/cordic_sc_step.sv */
// one registered cordic rotation step with its own valid bit
`timescale 1ns / 1ps

module cordic_sc_step (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [cordic_sc_pkg::SHIFT_W-1:0]      step_shift,
   input  logic signed [cordic_sc_pkg::RES_W-1:0] step_atan,
   input  logic                                   up_valid,
   output logic                                   up_ready,
   input  cordic_sc_pkg::vec_type                 up_data,
   output logic                                   down_valid,
   input  logic                                   down_ready,
   output cordic_sc_pkg::vec_type                 down_data
);

   logic                   vld_ff;
   cordic_sc_pkg::vec_type data_ff;
   cordic_sc_pkg::vec_type data_in;

   logic signed [cordic_sc_pkg::XY_W-1:0]  x_cur;
   logic signed [cordic_sc_pkg::XY_W-1:0]  y_cur;
   logic signed [cordic_sc_pkg::RES_W-1:0] r_cur;
   logic signed [cordic_sc_pkg::XY_W-1:0]  dx;
   logic signed [cordic_sc_pkg::XY_W-1:0]  dy;

   // stage moves when empty or when the next stage takes its item
   assign up_ready   = !vld_ff || down_ready;
   assign down_valid = vld_ff;
   assign down_data  = data_ff;

   // rotate toward zero residual
   always_comb begin
      x_cur = up_data.x;
      y_cur = up_data.y;
      r_cur = up_data.r;
      dx    = y_cur >>> step_shift;
      dy    = x_cur >>> step_shift;
      data_in = up_data;
      if (r_cur < 0) begin
         data_in.x = x_cur + dx;
         data_in.y = y_cur - dy;
         data_in.r = r_cur + step_atan;
      end else begin
         data_in.x = x_cur - dx;
         data_in.y = y_cur + dy;
         data_in.r = r_cur - step_atan;
      end
   end

   // stage valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (up_ready) begin
         vld_ff <= up_valid;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

endmodule
